>>> src/pidfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_pkg
// Shared widths, request codes and register map of the PID controller with
// clamped integral and low-pass filtered derivative.
// ----------------------------------------------------------------------------
package pidfd_pkg;

    // Fixed field widths and fixed-point formats
    localparam int ERR_W     = 32;   // Q16.16 error
    localparam int GAIN_W    = 32;   // Q16.16 gains
    localparam int DT_W      = 32;   // Q8.24 step time
    localparam int LIM_W     = 31;   // Q15.16 integral clamp magnitude
    localparam int DERIV_W   = 40;   // Q24.16 filtered derivative
    localparam int GAIN_FRAC = 16;
    localparam int DT_FRAC   = 24;

    // Defaults for the top-level parameters
    localparam int DATA_WIDTH_DEF      = 32;
    localparam int ALPHA_FRAC_BITS_DEF = 16;

    // 0.0025 s in Q8.24
    localparam logic [DT_W-1:0] STEP_TIME_RST = 32'd41943;

    // Request types
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_KP      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KI      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KD      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ILIM    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DFLT_DT = 3'd5;

endpackage

>>> src/pidfd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_req_if / pidfd_rsp_if
// Valid/ready channels for controller requests and controller results.
// ----------------------------------------------------------------------------
interface pidfd_req_if
    import pidfd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic signed [ERR_W-1:0] error;
    logic        [DT_W-1:0]  step_time;

    modport source (output valid, output req_type, output error, output step_time,
                    input ready);
    modport sink   (input valid, input req_type, input error, input step_time,
                    output ready);
endinterface

interface pidfd_rsp_if
    import pidfd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] control_output;
    logic                         integral_clamped;

    modport source (output valid, output control_output, output integral_clamped,
                    input ready);
    modport sink   (input valid, input control_output, input integral_clamped,
                    output ready);
endinterface

>>> src/pidfd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidfd_div
// Restoring unsigned divider, one quotient bit per cycle. The dividend
// shifts out of the quotient register as the quotient bits shift in.
// ----------------------------------------------------------------------------
module pidfd_div #(
    parameter int NUM_W = 57,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [NUM_W-1:0] r_quo, n_quo;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial  = {r_rem, r_quo[NUM_W-1]};
        diff   = trial - {1'b0, r_den};
        ge     = (trial >= {1'b0, r_den});

        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;

        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = CNT_W'(NUM_W);
            n_rem  = '0;
            n_den  = i_den;
            n_quo  = i_num;
        end else if (r_busy) begin
            n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> src/pid_with_filtered_derivative_top.sv
`timescale 1ns / 1ps
// An update item runs the error multiplies, the dt multiply, the derivative
// filter and the kd multiply in turn before its result is registered.
// A new request is taken only in idle, so an update must finish before the
// next item is accepted; a clear item gives no result.
// Reset: synchronous, active low; resets loop state, filter, config registers.
// ----------------------------------------------------------------------------
// pid_with_filtered_derivative_top
// PID controller with clamped integral and first-order low-pass derivative.
// Multiplies run one multiplier bit per cycle through a shared shift
// register; the derivative divide runs in a parallel restoring divider.
// ----------------------------------------------------------------------------
module pid_with_filtered_derivative_top
    import pidfd_pkg::*;
#(
    parameter int DATA_WIDTH      = DATA_WIDTH_DEF,
    parameter int ALPHA_FRAC_BITS = ALPHA_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pidfd_req_if.sink             i_req,
    pidfd_rsp_if.source           o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Datapath widths
    localparam int MB_W      = GAIN_W;
    localparam int CNT_W     = $clog2(MB_W);
    localparam int PROD_W    = GAIN_W + ERR_W;
    localparam int P_W       = PROD_W - GAIN_FRAC + 1;
    localparam int INC_SH    = GAIN_FRAC + DT_FRAC - DT_W;
    localparam int INC_MAG_W = PROD_W - INC_SH;
    localparam int SUM_W     = INC_MAG_W + 2;
    localparam int DIFF_W    = ERR_W + 1;
    localparam int NUM_W     = DIFF_W + DT_FRAC;
    localparam int AW        = ALPHA_FRAC_BITS + 1;
    localparam int DELTA_W   = DERIV_W + 1;
    localparam int FACC_W    = DELTA_W + AW;
    localparam int FSUM_W    = FACC_W + 1;
    localparam int KD_PROD_W = DERIV_W + GAIN_W;
    localparam int D_MAG_W   = KD_PROD_W - GAIN_FRAC;
    localparam int D_W       = D_MAG_W + 1;
    localparam int TOT_W     = D_W + 2;

    localparam logic [AW-1:0] ALPHA_ONE = {1'b1, {ALPHA_FRAC_BITS{1'b0}}};
    localparam logic signed [FSUM_W-1:0] TRUNC_BIAS =
        {{(FSUM_W-ALPHA_FRAC_BITS){1'b0}}, {ALPHA_FRAC_BITS{1'b1}}};
    localparam logic signed [DERIV_W-1:0] RAW_MAX = {1'b0, {(DERIV_W-1){1'b1}}};
    localparam logic signed [DERIV_W-1:0] RAW_MIN = {1'b1, {(DERIV_W-1){1'b0}}};
    localparam logic signed [TOT_W-1:0] OUT_MAX =
        {{(TOT_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [TOT_W-1:0] OUT_MIN = ~OUT_MAX;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_MUL2  = 4'd2;
    localparam logic [3:0] S_INT   = 4'd3;
    localparam logic [3:0] S_DERIV = 4'd4;
    localparam logic [3:0] S_FILT  = 4'd5;
    localparam logic [3:0] S_FDONE = 4'd6;
    localparam logic [3:0] S_KD    = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    function automatic logic [MB_W-1:0] mag_w(input logic [MB_W-1:0] v);
        return v[MB_W-1] ? (~v + 1'b1) : v;
    endfunction

    // Configuration registers
    logic signed [GAIN_W-1:0] r_kp, n_kp;
    logic signed [GAIN_W-1:0] r_ki, n_ki;
    logic signed [GAIN_W-1:0] r_kd, n_kd;
    logic [LIM_W-1:0]         r_ilim, n_ilim;
    logic [AW-1:0]            r_alpha, n_alpha;
    logic [DT_W-1:0]          r_dflt_dt, n_dflt_dt;

    // Loop state
    logic signed [ERR_W-1:0]   r_prev, n_prev;
    logic signed [ERR_W-1:0]   r_isum, n_isum;
    logic signed [DERIV_W-1:0] r_filt, n_filt;
    logic [DT_W-1:0]           r_act_dt, n_act_dt;

    // Control
    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    // Working registers
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic [DT_W-1:0]           r_dt, n_dt;
    logic [MB_W-1:0]           r_mb, n_mb;
    logic [PROD_W-1:0]         r_acc_p, n_acc_p;
    logic [PROD_W-1:0]         r_acc_i, n_acc_i;
    logic [PROD_W-1:0]         r_acc2, n_acc2;
    logic signed [P_W-1:0]     r_p, n_p;
    logic                      r_clamp, n_clamp;
    logic                      r_diff_neg, n_diff_neg;
    logic                      r_dt_zero, n_dt_zero;
    logic signed [DELTA_W-1:0] r_delta, n_delta;
    logic signed [FACC_W-1:0]  r_acc_f, n_acc_f;
    logic [DERIV_W-1:0]        r_fm, n_fm;
    logic [DERIV_W-1:0]        r_acc_d, n_acc_d;
    logic                      r_d_neg, n_d_neg;
    logic signed [DATA_WIDTH-1:0] r_out, n_out;
    logic                      r_out_clamp, n_out_clamp;

    // Combinational helpers
    logic                      cfg_wr;
    logic [REG_IDX_W-1:0]      cfg_idx;
    logic [DT_W-1:0]           dt_sel;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         diff_mag;
    logic [NUM_W-1:0]          div_num;
    logic                      div_start;
    logic                      div_done;
    logic [NUM_W-1:0]          div_quo;
    logic [MB_W-1:0]           kp_mag, ki_mag, kd_mag;
    logic [PROD_W:0]           sum2;
    logic [P_W-2:0]            p_mag;
    logic signed [P_W-1:0]     p_pos;
    logic [INC_MAG_W-1:0]      inc_mag;
    logic signed [SUM_W-1:0]   inc_pos, isum_new, lim_pos;
    logic                      raw_over;
    logic signed [DERIV_W-1:0] raw;
    logic [AW-1:0]             alpha_eff;
    logic signed [FSUM_W-1:0]  fsum, fsum_adj, fshift;
    logic signed [DERIV_W-1:0] f_new;
    logic [DERIV_W:0]          sumd;
    logic [D_MAG_W-1:0]        d_mag;
    logic signed [D_W-1:0]     d_pos, d_val;
    logic signed [TOT_W-1:0]   tot;
    logic signed [DATA_WIDTH-1:0] tot_sat;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign pready  = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            REG_KP:      prdata = r_kp;
            REG_KI:      prdata = r_ki;
            REG_KD:      prdata = r_kd;
            REG_ILIM:    prdata = CFG_DATA_W'(r_ilim);
            REG_ALPHA:   prdata = CFG_DATA_W'(r_alpha);
            REG_DFLT_DT: prdata = r_dflt_dt;
            default:     prdata = '0;
        endcase
    end

    // Step time in use and the divider operands
    assign dt_sel   = (i_req.step_time != '0) ? i_req.step_time :
                      ((r_act_dt != '0) ? r_act_dt : r_dflt_dt);
    assign diff     = DIFF_W'(i_req.error) - DIFF_W'(r_prev);
    assign diff_mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    assign div_num  = {diff_mag, {DT_FRAC{1'b0}}};

    assign kp_mag = mag_w(r_kp);
    assign ki_mag = mag_w(r_ki);
    assign kd_mag = mag_w(r_kd);

    pidfd_div #(
        .NUM_W (NUM_W),
        .DEN_W (DT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (dt_sel),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Datapath terms read by the sequencer
    always_comb begin
        sum2     = {1'b0, r_acc2} + (r_mb[0] ? {1'b0, r_acc_i} : '0);

        p_mag    = r_acc_p[PROD_W-1:GAIN_FRAC];
        p_pos    = $signed({1'b0, p_mag});

        inc_mag  = r_acc2[PROD_W-1:INC_SH];
        inc_pos  = $signed({2'b00, inc_mag});
        lim_pos  = $signed(SUM_W'(r_ilim));
        isum_new = SUM_W'(r_isum) + ((r_ki[GAIN_W-1] ^ r_err[ERR_W-1]) ? -inc_pos : inc_pos);

        raw_over = |div_quo[NUM_W-1:DERIV_W-1];
        if (r_dt_zero) begin
            raw = '0;
        end else if (r_diff_neg) begin
            raw = raw_over ? RAW_MIN : -$signed(div_quo[DERIV_W-1:0]);
        end else begin
            raw = raw_over ? RAW_MAX : $signed({1'b0, div_quo[DERIV_W-2:0]});
        end

        // Alpha above one acts as one
        alpha_eff = (r_alpha[AW-1] && (r_alpha[AW-2:0] != '0)) ? ALPHA_ONE : r_alpha;

        fsum     = (FSUM_W'(r_filt) <<< ALPHA_FRAC_BITS) + FSUM_W'(r_acc_f);
        fsum_adj = fsum[FSUM_W-1] ? (fsum + TRUNC_BIAS) : fsum;
        fshift   = fsum_adj >>> ALPHA_FRAC_BITS;
        f_new    = fshift[DERIV_W-1:0];

        sumd     = {1'b0, r_acc_d} + (r_mb[0] ? {1'b0, r_fm} : '0);

        d_mag    = {r_acc_d, r_mb[MB_W-1:GAIN_FRAC]};
        d_pos    = $signed({1'b0, d_mag});
        d_val    = r_d_neg ? -d_pos : d_pos;

        tot      = TOT_W'(r_p) + TOT_W'(r_isum) + TOT_W'(d_val);
        if (tot > OUT_MAX) begin
            tot_sat = OUT_MAX[DATA_WIDTH-1:0];
        end else if (tot < OUT_MIN) begin
            tot_sat = OUT_MIN[DATA_WIDTH-1:0];
        end else begin
            tot_sat = tot[DATA_WIDTH-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_kp        = r_kp;
        n_ki        = r_ki;
        n_kd        = r_kd;
        n_ilim      = r_ilim;
        n_alpha     = r_alpha;
        n_dflt_dt   = r_dflt_dt;
        n_prev      = r_prev;
        n_isum      = r_isum;
        n_filt      = r_filt;
        n_act_dt    = r_act_dt;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_err       = r_err;
        n_dt        = r_dt;
        n_mb        = r_mb;
        n_acc_p     = r_acc_p;
        n_acc_i     = r_acc_i;
        n_acc2      = r_acc2;
        n_p         = r_p;
        n_clamp     = r_clamp;
        n_diff_neg  = r_diff_neg;
        n_dt_zero   = r_dt_zero;
        n_delta     = r_delta;
        n_acc_f     = r_acc_f;
        n_fm        = r_fm;
        n_acc_d     = r_acc_d;
        n_d_neg     = r_d_neg;
        n_out       = r_out;
        n_out_clamp = r_out_clamp;
        div_start   = 1'b0;

        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_KP:      n_kp      = pwdata[GAIN_W-1:0];
                REG_KI:      n_ki      = pwdata[GAIN_W-1:0];
                REG_KD:      n_kd      = pwdata[GAIN_W-1:0];
                REG_ILIM:    n_ilim    = pwdata[LIM_W-1:0];
                REG_ALPHA:   n_alpha   = pwdata[AW-1:0];
                REG_DFLT_DT: n_dflt_dt = pwdata[DT_W-1:0];
                default:     ;
            endcase
        end

        // Drop the result once its transfer completes
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.req_type == REQ_CLEAR) begin
                        n_prev = '0;
                        n_isum = '0;
                    end else begin
                        n_err      = i_req.error;
                        n_dt       = dt_sel;
                        if (i_req.step_time != '0) begin
                            n_act_dt = i_req.step_time;
                        end
                        n_mb       = mag_w(i_req.error);
                        n_acc_p    = '0;
                        n_acc_i    = '0;
                        n_diff_neg = diff[DIFF_W-1];
                        n_dt_zero  = (dt_sel == '0);
                        n_cnt      = CNT_W'(MB_W - 1);
                        div_start  = 1'b1;
                        n_state    = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                // |kp|*|err| and |ki|*|err| together, error bits MSB first
                n_acc_p = {r_acc_p[PROD_W-2:0], 1'b0} +
                          (r_mb[MB_W-1] ? PROD_W'(kp_mag) : '0);
                n_acc_i = {r_acc_i[PROD_W-2:0], 1'b0} +
                          (r_mb[MB_W-1] ? PROD_W'(ki_mag) : '0);
                n_mb    = {r_mb[MB_W-2:0], 1'b0};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_mb    = r_dt;
                    n_acc2  = '0;
                    n_cnt   = CNT_W'(MB_W - 1);
                    n_state = S_MUL2;
                end
            end
            S_MUL2: begin
                // Times dt, LSB first; low product bits fall off the bottom
                n_acc2 = sum2[PROD_W:1];
                n_mb   = {sum2[0], r_mb[MB_W-1:1]};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_INT;
                end
            end
            S_INT: begin
                n_p = (r_kp[GAIN_W-1] ^ r_err[ERR_W-1]) ? -p_pos : p_pos;
                if (isum_new > lim_pos) begin
                    n_isum  = lim_pos[ERR_W-1:0];
                    n_clamp = 1'b1;
                end else if (isum_new < -lim_pos) begin
                    n_isum  = -lim_pos[ERR_W-1:0];
                    n_clamp = 1'b1;
                end else begin
                    n_isum  = isum_new[ERR_W-1:0];
                    n_clamp = 1'b0;
                end
                n_state = S_DERIV;
            end
            S_DERIV: begin
                // Hold until the quotient is in
                if (div_done) begin
                    n_delta = DELTA_W'(raw) - DELTA_W'(r_filt);
                    n_mb    = MB_W'(alpha_eff) << (MB_W - AW);
                    n_acc_f = '0;
                    n_cnt   = CNT_W'(AW - 1);
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                // alpha*(raw - f), alpha bits MSB first
                n_acc_f = (r_acc_f <<< 1) + (r_mb[MB_W-1] ? FACC_W'(r_delta) : '0);
                n_mb    = {r_mb[MB_W-2:0], 1'b0};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FDONE;
                end
            end
            S_FDONE: begin
                n_filt  = f_new;
                n_fm    = f_new[DERIV_W-1] ? DERIV_W'(-f_new) : DERIV_W'(f_new);
                n_d_neg = r_kd[GAIN_W-1] ^ f_new[DERIV_W-1];
                n_mb    = kd_mag;
                n_acc_d = '0;
                n_cnt   = CNT_W'(MB_W - 1);
                n_state = S_KD;
            end
            S_KD: begin
                n_acc_d = sumd[DERIV_W:1];
                n_mb    = {sumd[0], r_mb[MB_W-1:1]};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hold while the previous result still waits
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = tot_sat;
                    n_out_clamp = r_clamp;
                    n_out_valid = 1'b1;
                    n_prev      = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_ilim      <= '0;
            r_alpha     <= '0;
            r_dflt_dt   <= STEP_TIME_RST;
            r_prev      <= '0;
            r_isum      <= '0;
            r_filt      <= '0;
            r_act_dt    <= '0;
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_kp        <= n_kp;
            r_ki        <= n_ki;
            r_kd        <= n_kd;
            r_ilim      <= n_ilim;
            r_alpha     <= n_alpha;
            r_dflt_dt   <= n_dflt_dt;
            r_prev      <= n_prev;
            r_isum      <= n_isum;
            r_filt      <= n_filt;
            r_act_dt    <= n_act_dt;
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err       <= n_err;
        r_dt        <= n_dt;
        r_mb        <= n_mb;
        r_acc_p     <= n_acc_p;
        r_acc_i     <= n_acc_i;
        r_acc2      <= n_acc2;
        r_p         <= n_p;
        r_clamp     <= n_clamp;
        r_diff_neg  <= n_diff_neg;
        r_dt_zero   <= n_dt_zero;
        r_delta     <= n_delta;
        r_acc_f     <= n_acc_f;
        r_fm        <= n_fm;
        r_acc_d     <= n_acc_d;
        r_d_neg     <= n_d_neg;
        r_out       <= n_out;
        r_out_clamp <= n_out_clamp;
    end

    assign i_req.ready            = (r_state == S_IDLE);
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.control_output   = r_out;
    assign o_rsp.integral_clamped = r_out_clamp;

endmodule
